/* sv/clt_pkg.sv */
// Shared types, address map constants and helper functions for the
// core-local timer and software interrupt block. No dependencies.
package clt_pkg;

  // Default hart count and the fixed number of interrupt lines at the ports.
  localparam int CLT_NUM_HARTS = 4;
  localparam int CLT_IRQ_LINES = 4;

  // Operation codes of a request.
  localparam logic [1:0] CLT_OP_TICK  = 2'd0;
  localparam logic [1:0] CLT_OP_READ  = 2'd1;
  localparam logic [1:0] CLT_OP_WRITE = 2'd2;

  // Register window layout; the two bases are one bit wider than the address for range checks.
  localparam logic [16:0] CLT_SOFT_BASE = 17'h0_0000;
  localparam logic [16:0] CLT_CMP_BASE  = 17'h0_4000;
  localparam logic [15:0] CLT_TIME_LO   = 16'hBFF8;
  localparam logic [15:0] CLT_TIME_HI   = 16'hBFFC;

  // One request as it arrives on the input channel.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] address;
    logic        wide;
    logic [63:0] write_data;
  } clt_req_t;

  // One result as it leaves on the output channel.
  typedef struct packed {
    logic [63:0]              read_data;
    logic [CLT_IRQ_LINES-1:0] soft_irq;
    logic [CLT_IRQ_LINES-1:0] timer_irq;
    logic                     unmapped;
  } clt_rsp_t;

  // Address decode result; the hart index travels separately.
  typedef struct packed {
    logic soft_hit;
    logic cmp_hit;
    logic time_hit;
    logic upper;
  } clt_dec_t;

  // Apply a 64-bit or 32-bit half write to a 64-bit register.
  function automatic logic [63:0] clt_merge(input logic [63:0] old_val,
                                            input logic [63:0] data,
                                            input logic        wide,
                                            input logic        upper);
    logic [63:0] res;
    begin
      if (wide) begin
        res = data;
      end else if (upper) begin
        res = {data[31:0], old_val[31:0]};
      end else begin
        res = {old_val[63:32], data[31:0]};
      end
      return res;
    end
  endfunction

  // Read a 64-bit register whole or as one 32-bit half.
  function automatic logic [63:0] clt_half(input logic [63:0] val,
                                           input logic        wide,
                                           input logic        upper);
    logic [63:0] res;
    begin
      if (wide) begin
        res = val;
      end else if (upper) begin
        res = {32'd0, val[63:32]};
      end else begin
        res = {32'd0, val[31:0]};
      end
      return res;
    end
  endfunction

endpackage

/* sv/clt_decode.sv */
// Address decoder for the register window of the core-local interruptor.
// Depends on clt_pkg for the address map and the decode struct.
module clt_decode
  import clt_pkg::*;
#(
  parameter int NUM_HARTS = CLT_NUM_HARTS,
  parameter int HART_W    = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1
) (
  input  logic [15:0]       address,
  input  logic              wide,
  output clt_dec_t          dec,
  output logic [HART_W-1:0] hart
);

  logic [16:0] addr_ext;
  logic        aligned;
  logic        soft_in;
  logic        cmp_in;
  logic        time_in;

  // Range checks on the aligned address.
  always_comb begin
    addr_ext = {1'b0, address};
    aligned  = (address[1:0] == 2'b00);
    soft_in  = aligned && (addr_ext >= CLT_SOFT_BASE) &&
               (addr_ext < 17'(CLT_SOFT_BASE + 17'(4 * NUM_HARTS)));
    cmp_in   = aligned && (addr_ext >= CLT_CMP_BASE) &&
               (addr_ext < 17'(CLT_CMP_BASE + 17'(8 * NUM_HARTS)));
    time_in  = (address == CLT_TIME_LO) || (address == CLT_TIME_HI);
  end

  // A 64-bit access to the upper half of a 64-bit register misses.
  always_comb begin
    dec.upper    = address[2];
    dec.soft_hit = soft_in;
    dec.cmp_hit  = cmp_in && !(wide && address[2]);
    dec.time_hit = time_in && !(wide && address[2]);
    hart         = soft_in ? address[2 +: HART_W] : address[3 +: HART_W];
  end

endmodule

/* sv/core_local_timer_and_soft_irq_core.sv */
// Top level of the core-local timer and software interrupt block.
// Depends on clt_pkg and instantiates clt_decode.
//
// Usage:
//   A request (tick, bus read or bus write) is taken at a rising edge where
//   start is high and busy is low. The fields travel in the in_req struct.
//   Each request gives exactly one result in out_rsp, shown for one cycle
//   with out_strobe high; the receiver cannot hold results off.
//   A request passes the input register, the register update with read
//   capture and the interrupt compare before its result strobe rises.
//   Throughput: one request every cycle while busy is low; the only loop is
//   the update of the time, compare and software-interrupt registers.
//   The interrupt lines in a result reflect the state after that request's
//   own update, compared unsigned per hart.
//   Reset (rst_n low, synchronous): time is cleared, every compare is set to
//   all ones, software bits are cleared and the pipeline is emptied. Busy is
//   high during reset and the first cycle after it, and low from then on.
module core_local_timer_and_soft_irq_core
  import clt_pkg::*;
#(
  parameter int NUM_HARTS = CLT_NUM_HARTS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  clt_req_t in_req,
  output logic     out_strobe,
  output clt_rsp_t out_rsp
);

  localparam int HartW = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;

  logic                 busy_r;
  logic                 req_vld_r;
  clt_req_t             req_r;
  logic [63:0]          time_r;
  logic [63:0]          time_nxt;
  logic [63:0]          cmp_r   [NUM_HARTS];
  logic [63:0]          cmp_nxt [NUM_HARTS];
  logic [NUM_HARTS-1:0] soft_r;
  logic [NUM_HARTS-1:0] soft_nxt;
  logic                 mid_vld_r;
  logic [63:0]          mid_rd_r;
  logic                 mid_miss_r;
  logic [63:0]          rd_nxt;
  logic                 miss_nxt;
  logic                 out_strobe_r;
  clt_rsp_t             out_rsp_r;
  clt_dec_t             dec;
  logic [HartW-1:0]     dec_hart;
  logic                 is_tick;
  logic                 is_read;
  logic                 is_write;
  logic [CLT_IRQ_LINES-1:0] soft_irq_w;
  logic [CLT_IRQ_LINES-1:0] timer_irq_w;

  // Busy only covers reset and the cycle right after it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      req_r <= in_req;
    end
  end

  // Address decode of the registered request.
  clt_decode #(
    .NUM_HARTS (NUM_HARTS),
    .HART_W    (HartW)
  ) u_decode (
    .address (req_r.address),
    .wide    (req_r.wide),
    .dec     (dec),
    .hart    (dec_hart)
  );

  // Operation flags, only while a request sits in the input register.
  always_comb begin
    is_tick  = req_vld_r && (req_r.opcode == CLT_OP_TICK);
    is_read  = req_vld_r && (req_r.opcode == CLT_OP_READ);
    is_write = req_vld_r && (req_r.opcode == CLT_OP_WRITE);
  end

  // Read data and miss flag; writes return zero data.
  always_comb begin
    rd_nxt   = 64'd0;
    miss_nxt = (is_read || is_write) &&
               !(dec.soft_hit || dec.cmp_hit || dec.time_hit);
    if (is_read) begin
      priority if (dec.soft_hit) begin
        rd_nxt = {63'd0, soft_r[dec_hart]};
      end else if (dec.cmp_hit) begin
        rd_nxt = clt_half(cmp_r[dec_hart], req_r.wide, dec.upper);
      end else if (dec.time_hit) begin
        rd_nxt = clt_half(time_r, req_r.wide, dec.upper);
      end
    end
  end

  // Next state of the time counter: a tick counts, a write overwrites.
  always_comb begin
    time_nxt = time_r;
    if (is_tick) begin
      time_nxt = time_r + 64'd1;
    end else if (is_write && dec.time_hit) begin
      time_nxt = clt_merge(time_r, req_r.write_data, req_r.wide, dec.upper);
    end
  end

  // Next state of the per-hart compare and software-interrupt registers.
  always_comb begin
    for (int h = 0; h < NUM_HARTS; h++) begin
      cmp_nxt[h]  = cmp_r[h];
      soft_nxt[h] = soft_r[h];
      if (is_write && (dec_hart == HartW'(h))) begin
        if (dec.cmp_hit) begin
          cmp_nxt[h] = clt_merge(cmp_r[h], req_r.write_data, req_r.wide,
                                 dec.upper);
        end
        if (dec.soft_hit) begin
          soft_nxt[h] = req_r.write_data[0];
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= 64'd0;
      soft_r <= '0;
      for (int h = 0; h < NUM_HARTS; h++) begin
        cmp_r[h] <= '1;
      end
    end else begin
      time_r <= time_nxt;
      soft_r <= soft_nxt;
      for (int h = 0; h < NUM_HARTS; h++) begin
        cmp_r[h] <= cmp_nxt[h];
      end
    end
  end

  // Middle stage holds the read result while the state settles.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_vld_r <= 1'b0;
    end else begin
      mid_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    mid_rd_r   <= rd_nxt;
    mid_miss_r <= miss_nxt;
  end

  // Interrupt lines from the updated state; harts past the port width drop.
  for (genvar g = 0; g < CLT_IRQ_LINES; g++) begin : g_irq
    if (g < NUM_HARTS) begin : g_live
      assign soft_irq_w[g]  = soft_r[g];
      assign timer_irq_w[g] = (time_r >= cmp_r[g]);
    end else begin : g_none
      assign soft_irq_w[g]  = 1'b0;
      assign timer_irq_w[g] = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= mid_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r.read_data <= mid_rd_r;
    out_rsp_r.soft_irq  <= soft_irq_w;
    out_rsp_r.timer_irq <= timer_irq_w;
    out_rsp_r.unmapped  <= mid_miss_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

endmodule

/* sv/clt_checker.sv */
// Port-level checks for the core-local timer and software interrupt block.
// Depends on clt_pkg; bound to core_local_timer_and_soft_irq_core below.
module clt_checker
  import clt_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input clt_req_t in_req,
  input logic     out_strobe,
  input clt_rsp_t out_rsp
);

  // Every accepted request is followed by a result strobe.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("accepted request gave no result");

  // No result appears without an earlier accepted request.
  a_result_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 3))
    else $error("result without a matching request");

  // A miss only comes from a bus read or write, and carries zero data.
  a_miss_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_rsp.unmapped) |->
      (($past(in_req.opcode, 3) == CLT_OP_READ) ||
       ($past(in_req.opcode, 3) == CLT_OP_WRITE)) &&
      (out_rsp.read_data == 64'd0))
    else $error("miss flag on a request that cannot miss");

  // Nonzero read data only comes from a bus read.
  a_data_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_rsp.read_data != 64'd0)) |->
      ($past(in_req.opcode, 3) == CLT_OP_READ))
    else $error("read data on a request that is not a read");

endmodule

bind core_local_timer_and_soft_irq_core clt_checker u_clt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_req     (in_req),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp)
);
